>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the framer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define XBF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check prop at the clock edge after any edge at which reset is held.
`define XBF_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) !rstn |=> prop) else $error(msg);

`endif

>>> rtl/core/xbf_pkg.sv
// ----------------------------------------------------------------------------
// xbf_pkg
// Constants, command/status types and the CRC-16 byte update for the framer.
// ----------------------------------------------------------------------------
package xbf_pkg;

  localparam int unsigned ChunkBytes = 128;
  localparam int unsigned CntW       = $clog2(ChunkBytes + 1);

  localparam logic [CntW-1:0] ChunkCnt = CntW'(ChunkBytes);
  localparam logic [CntW-1:0] LastCnt  = CntW'(ChunkBytes - 1);

  localparam logic [7:0]  SohByte = 8'h01;
  localparam logic [7:0]  PadByte = 8'h1A;
  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef enum logic [2:0] {
    OSEL_SOH,
    OSEL_NUM,
    OSEL_CMP,
    OSEL_DATA,
    OSEL_PAD,
    OSEL_CRC_HI,
    OSEL_TRL_LO
  } out_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     open_blk;
    logic     clr_blknum;
    logic     absorb_data;
    logic     absorb_pad;
    logic     close_blk;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic in_block;
    logic full_next;
    logic crc_mode;
  } dp_status_t;

  // CRC-16/XMODEM, MSB first, one byte.
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/xbf_dp.sv
// ----------------------------------------------------------------------------
// xbf_dp
// Framer datapath: block state, running sum and CRC, output payload register.
// ----------------------------------------------------------------------------
module xbf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic [7:0]          data_byte_i,
  input  xbf_pkg::dp_cmd_t    cmd_i,
  output xbf_pkg::dp_status_t status_o,
  output logic [7:0]          frame_byte_o,
  output logic [7:0]          repeat_count_o,
  output logic                block_end_o,
  output logic                last_o
);
  import xbf_pkg::*;

  logic            crc_mode_q;
  logic            in_block_q, in_block_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      blknum_q, blknum_d;
  logic [7:0]      sum_q, sum_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      byte_q;

  logic [7:0]      frame_q, frame_d;
  logic [7:0]      rep_q, rep_d;
  logic            bend_q, bend_d;
  logic            last_q;

  logic [7:0]      absorb_byte;
  logic [CntW-1:0] pad_cnt;

  assign absorb_byte = cmd_i.absorb_pad ? PadByte : byte_q;
  assign pad_cnt     = ChunkCnt - cnt_q;

  always_comb begin
    in_block_d = in_block_q;
    cnt_d      = cnt_q;
    blknum_d   = blknum_q;
    sum_d      = sum_q;
    crc_d      = crc_q;
    if (cmd_i.clr_blknum) begin
      blknum_d = '0;
    end
    if (cmd_i.open_blk) begin
      blknum_d   = blknum_q + 8'd1;
      in_block_d = 1'b1;
      cnt_d      = '0;
      sum_d      = '0;
      crc_d      = '0;
    end
    if (cmd_i.absorb_data || cmd_i.absorb_pad) begin
      sum_d = sum_q + absorb_byte;
      crc_d = crc_update(crc_q, absorb_byte);
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd_i.close_blk) begin
      in_block_d = 1'b0;
      cnt_d      = '0;
      sum_d      = '0;
      crc_d      = '0;
    end
  end

  always_comb begin
    frame_d = byte_q;
    rep_d   = 8'd1;
    bend_d  = 1'b0;
    unique case (cmd_i.out_sel)
      OSEL_SOH:    frame_d = SohByte;
      OSEL_NUM:    frame_d = blknum_q;
      OSEL_CMP:    frame_d = ~blknum_q;
      OSEL_DATA:   frame_d = byte_q;
      OSEL_PAD: begin
        frame_d = PadByte;
        rep_d   = 8'(pad_cnt);
      end
      OSEL_CRC_HI: frame_d = crc_q[15:8];
      OSEL_TRL_LO: begin
        frame_d = crc_mode_q ? crc_q[7:0] : sum_q;
        bend_d  = 1'b1;
      end
      default:     frame_d = byte_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_mode_q <= 1'b1;
      in_block_q <= 1'b0;
      cnt_q      <= '0;
      blknum_q   <= '0;
      sum_q      <= '0;
      crc_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        crc_mode_q <= cfg_wdata_i;
      end
      in_block_q <= in_block_d;
      cnt_q      <= cnt_d;
      blknum_q   <= blknum_d;
      sum_q      <= sum_d;
      crc_q      <= crc_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      byte_q <= data_byte_i;
    end
    if (cmd_i.out_load) begin
      frame_q <= frame_d;
      rep_q   <= rep_d;
      bend_q  <= bend_d;
      last_q  <= cmd_i.out_last;
    end
  end

  assign status_o.in_block  = in_block_q;
  assign status_o.full_next = (cnt_q == LastCnt);
  assign status_o.crc_mode  = crc_mode_q;

  assign frame_byte_o   = frame_q;
  assign repeat_count_o = rep_q;
  assign block_end_o    = bend_q;
  assign last_o         = last_q;

endmodule

>>> rtl/core/xbf_ctrl.sv
// ----------------------------------------------------------------------------
// xbf_ctrl
// Framer controller: sequences header, data, pad and trailer results.
// ----------------------------------------------------------------------------
module xbf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  xbf_pkg::dp_status_t status_i,
  output xbf_pkg::dp_cmd_t    cmd_o
);
  import xbf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SOH,
    S_NUM,
    S_CMP,
    S_DATA,
    S_PAD,
    S_PADRUN,
    S_TRL_HI,
    S_TRL_LO
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    slot_free;
  state_e  trl_state;
  dp_cmd_t cmd;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign trl_state  = status_i.crc_mode ? S_TRL_HI : S_TRL_LO;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.out_sel = OSEL_DATA;
    state_d     = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          if (!mode_i) begin
            state_d = status_i.in_block ? S_DATA : S_SOH;
          end else begin
            cmd.clr_blknum = 1'b1;
            if (status_i.in_block) begin
              state_d = S_PAD;
            end
          end
        end
      end
      S_SOH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_SOH;
          cmd.open_blk = 1'b1;
          state_d      = S_NUM;
        end
      end
      S_NUM: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_NUM;
          state_d      = S_CMP;
        end
      end
      S_CMP: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_CMP;
          state_d      = S_DATA;
        end
      end
      S_DATA: begin
        if (slot_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_sel     = OSEL_DATA;
          cmd.absorb_data = 1'b1;
          cmd.out_last    = !status_i.full_next;
          state_d         = status_i.full_next ? trl_state : S_IDLE;
        end
      end
      S_PAD: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_PAD;
          state_d      = S_PADRUN;
        end
      end
      S_PADRUN: begin
        // fold one pad byte per cycle into sum and CRC
        cmd.absorb_pad = 1'b1;
        if (status_i.full_next) begin
          state_d = trl_state;
        end
      end
      S_TRL_HI: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_CRC_HI;
          state_d      = S_TRL_LO;
        end
      end
      S_TRL_LO: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OSEL_TRL_LO;
          cmd.out_last  = 1'b1;
          cmd.close_blk = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd.out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/xmodem_block_framer.sv
// ----------------------------------------------------------------------------
// xmodem_block_framer
// Frames file bytes into XMODEM blocks with checksum or CRC-16 trailer.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------------------
//   in      | in_valid_i / in_stall_o   | mode_i, data_byte_i
//   out     | out_valid_o / out_stall_i | frame_byte_o, repeat_count_o,
//           |                           |   block_end_o, last_o
//   cfg     | cfg_we_i                  | cfg_wdata_i (crc_mode)
//
// One item at a time: the input is taken in idle, then each result passes
// through the output register. An item causes 0 to 4 results. End of file
// on an open block also walks the pad bytes through the CRC unit, one per cycle.
// Output stall holds the result register and, outside the pad walk, the
// sequencer; input stalls in every state but idle. Reset leaves crc_mode at 1
// and no block open.
// ----------------------------------------------------------------------------
module xmodem_block_framer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic [7:0] repeat_count_o,
  output logic       block_end_o,
  output logic       last_o
);
  import xbf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  xbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  xbf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .frame_byte_o  (frame_byte_o),
    .repeat_count_o(repeat_count_o),
    .block_end_o   (block_end_o),
    .last_o        (last_o)
  );

endmodule

>>> rtl/core/xbf_checker.sv
// ----------------------------------------------------------------------------
// xbf_checker
// Port-level checks on the framer's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xbf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] frame_byte_o,
  input logic [7:0] repeat_count_o,
  input logic       block_end_o,
  input logic       last_o
);
  import xbf_pkg::*;

  `XBF_ASSERT_RST(a_no_beat_after_reset, clk_i, rst_ni, !out_valid_o,
                  "result valid after reset")
  `XBF_ASSERT(a_out_hold, clk_i, rst_ni,
              out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o)
                && $stable(repeat_count_o) && $stable(last_o),
              "stalled result changed")
  `XBF_ASSERT(a_rep_range, clk_i, rst_ni,
              out_valid_o |-> repeat_count_o >= 8'd1 && repeat_count_o <= 8'(ChunkBytes),
              "repeat count out of range")
  `XBF_ASSERT(a_rep_is_pad, clk_i, rst_ni,
              out_valid_o && repeat_count_o != 8'd1 |-> frame_byte_o == PadByte && !block_end_o,
              "repeated byte is not the pad")
  `XBF_ASSERT(a_end_is_last, clk_i, rst_ni, out_valid_o && block_end_o |-> last_o,
              "block end not the last beat of its item")

endmodule

bind xmodem_block_framer xbf_checker u_xbf_checker (.*);
